[hw/rtl/box_blur_and_unsharp_mask_defines.svh]
`ifndef BOX_BLUR_AND_UNSHARP_MASK_DEFINES_SVH
`define BOX_BLUR_AND_UNSHARP_MASK_DEFINES_SVH

// same-cycle implication, reset masks the check
`define BBUM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bbum check failed");

// next-cycle implication
`define BBUM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bbum check failed");

`endif

[hw/rtl/bbum_pkg.sv]
package bbum_pkg;

    localparam int MAX_RADIUS_DEF = 7;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int LANES   = 3;
    localparam int QUOT_W  = 8;

    localparam logic [2:0]  RADIUS_RST = 3'd0;
    localparam logic [11:0] WIDTH_RST  = 12'd640;
    localparam logic [12:0] HEIGHT_RST = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS  = 2'd0,
        REG_WIDTH   = 2'd1,
        REG_HEIGHT  = 2'd2,
        REG_SHARPEN = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [10:0] col;
        logic [11:0] row;
        logic        frame_end;
    } t_pix_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

[hw/rtl/bbum_ram.sv]
module bbum_ram import bbum_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/bbum_div.sv]
// three-lane restoring divider, one quotient bit per cycle, msb first
module bbum_div import bbum_pkg::*; #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [NUM_W-1:0]       i_num [LANES],
    input  logic [DEN_W-1:0]       i_den,
    output logic [QUOT_W-1:0]      o_quot [LANES],
    output t_div_status            o_status
);

    localparam int SHW = NUM_W + QUOT_W;

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [$clog2(QUOT_W)-1:0]  r_step, n_step;
    logic [DEN_W-1:0]           r_den, n_den;
    logic [NUM_W-1:0]           r_rem  [LANES];
    logic [NUM_W-1:0]           n_rem  [LANES];
    logic [QUOT_W-1:0]          r_quot [LANES];
    logic [QUOT_W-1:0]          n_quot [LANES];
    logic [SHW-1:0]             w_dsh;

    assign w_dsh = SHW'(r_den) << r_step;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = ($clog2(QUOT_W))'(QUOT_W - 1);
            n_den  = i_den;
            n_rem  = i_num;
            for (int c = 0; c < LANES; c++) begin
                n_quot[c] = '0;
            end
        end else if (r_busy) begin
            for (int c = 0; c < LANES; c++) begin
                if (SHW'(r_rem[c]) >= w_dsh) begin
                    n_rem[c]          = r_rem[c] - NUM_W'(w_dsh);
                    n_quot[c][r_step] = 1'b1;
                end
            end
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_quot          = r_quot;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule

[hw/rtl/box_blur_and_unsharp_mask.sv]
// Timing: a pixel that completes no window passes RD0, RD1 and RD2 and returns to idle;
// a pixel that completes a window goes on through the divider and the output load.
// One pixel at a time: o_stall is high outside idle. Inside the window a pixel takes the
// memory states RD0-RD2, the divider steps, the done cycle and the output load, which waits on i_stall.
// Reset (synchronous, active low): registers to radius 0, 640x480, blur mode, frame at (0,0).
// No clearing pass: line-store and column-sum contents need none.
`include "box_blur_and_unsharp_mask_defines.svh"
module box_blur_and_unsharp_mask import bbum_pkg::*; #(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // pixel in
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_pix_in               i_pix,
    // pixel out
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_pix_out              o_pix
);

    // geometry
    localparam int SL   = 2 * MAX_RADIUS + 1;            // lines kept
    localparam int YMW  = $clog2(SL);                    // line slot index
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int SW   = $clog2(SL + 1);
    localparam int AREAW = $clog2(SL * SL + 1);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int CW   = $clog2(SL * 255 + 1);          // column sum per channel
    localparam int WW   = $clog2(SL * SL * 255 + 1);     // window sum per channel
    localparam int LDEPTH = SL * MAX_WIDTH;
    localparam int LAW  = $clog2(LDEPTH);

    // sequencer: one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD0  = 6'b000010,   // read old line pixel and column sum at x
        S_RD1  = 6'b000100,   // update column sum, write line, read centre and x-side
        S_RD2  = 6'b001000,   // update window sums, start divider
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000    // load output register
    } t_state;

    t_state r_state, n_state;

    // config registers
    logic [2:0]  r_rad;
    logic [11:0] r_wid;
    logic [12:0] r_hgt;
    logic        r_sharp;

    // frame position
    logic [XW-1:0]  r_col, n_col;
    logic [YW-1:0]  r_row, n_row;
    logic [YMW-1:0] r_ymod, n_ymod;

    // per-transaction working registers
    t_pix_in          r_px;
    logic [3*CW-1:0]  r_ncs;
    logic [23:0]      r_ctr;
    logic [WW-1:0]    r_win [LANES];
    logic [WW-1:0]    n_win [LANES];

    // output register
    logic     r_oval;
    t_pix_out r_out;

    // effective config
    logic [RW-1:0]    w_r;
    logic [SW-1:0]    w_side;
    logic [AREAW-1:0] w_area;
    logic [XW:0]      w_w;
    logic [YW:0]      w_h;
    logic             w_emit;
    logic             w_last;
    logic             w_in_acc;

    always_comb begin
        w_r = (32'(r_rad) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_rad);
        w_side = SW'({w_r, 1'b1});
        w_area = AREAW'(w_side) * AREAW'(w_side);
        if (r_wid == '0) begin
            w_w = (XW+1)'(1);
        end else if (32'(r_wid) > MAX_WIDTH) begin
            w_w = (XW+1)'(MAX_WIDTH);
        end else begin
            w_w = (XW+1)'(r_wid);
        end
        if (r_hgt == '0) begin
            w_h = (YW+1)'(1);
        end else if (32'(r_hgt) > MAX_HEIGHT) begin
            w_h = (YW+1)'(MAX_HEIGHT);
        end else begin
            w_h = (YW+1)'(r_hgt);
        end
    end

    assign w_emit = (32'(r_col) >= 32'(2 * w_r)) && (32'(r_row) >= 32'(2 * w_r));
    assign w_last = ((XW+1)'(r_col) == w_w - 1'b1) && ((YW+1)'(r_row) == w_h - 1'b1);
    assign w_in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // line slot of the leaving row and of the centre row, mod SL
    logic [YMW:0] w_old_t, w_ctr_t;
    logic [YMW-1:0] w_old_slot, w_ctr_slot;
    always_comb begin
        w_old_t = (YMW+1)'(r_ymod) + (YMW+1)'(SL) - (YMW+1)'(w_side);
        w_ctr_t = (YMW+1)'(r_ymod) + (YMW+1)'(SL) - (YMW+1)'(w_r);
        w_old_slot = (w_old_t >= (YMW+1)'(SL)) ? YMW'(w_old_t - (YMW+1)'(SL)) : YMW'(w_old_t);
        w_ctr_slot = (w_ctr_t >= (YMW+1)'(SL)) ? YMW'(w_ctr_t - (YMW+1)'(SL)) : YMW'(w_ctr_t);
    end

    logic [XW-1:0] w_cx;
    logic [YW-1:0] w_cy;
    assign w_cx = r_col - XW'(w_r);
    assign w_cy = r_row - YW'(w_r);

    // line store
    logic           w_l_we;
    logic [LAW-1:0] w_l_waddr, w_l_raddr;
    logic [23:0]    w_l_rdata;

    assign w_l_we    = (r_state == S_RD1);
    assign w_l_waddr = LAW'(r_ymod) * LAW'(MAX_WIDTH) + LAW'(r_col);
    assign w_l_raddr = (r_state == S_RD0)
                       ? LAW'(w_old_slot) * LAW'(MAX_WIDTH) + LAW'(r_col)
                       : LAW'(w_ctr_slot) * LAW'(MAX_WIDTH) + LAW'(w_cx);

    bbum_ram #(.DEPTH(LDEPTH), .WIDTH(24)) u_lines (
        .i_clk   (i_clk),
        .i_we    (w_l_we),
        .i_waddr (w_l_waddr),
        .i_wdata (r_px),
        .i_raddr (w_l_raddr),
        .o_rdata (w_l_rdata)
    );

    // column sums
    logic [XW-1:0]   w_c_raddr;
    logic [3*CW-1:0] w_c_rdata;
    logic [3*CW-1:0] w_ncs;

    assign w_c_raddr = (r_state == S_RD0) ? r_col : (r_col - XW'(w_side));

    bbum_ram #(.DEPTH(MAX_WIDTH), .WIDTH(3*CW)) u_cols (
        .i_clk   (i_clk),
        .i_we    (w_l_we),
        .i_waddr (r_col),
        .i_wdata (w_ncs),
        .i_raddr (w_c_raddr),
        .o_rdata (w_c_rdata)
    );

    // column sum update; first row of a frame sees zero, rows before the window see no leaving pixel
    logic [7:0] w_pxl [LANES];
    logic [7:0] w_oldl [LANES];
    always_comb begin
        w_pxl[0]  = r_px.red_in;
        w_pxl[1]  = r_px.green_in;
        w_pxl[2]  = r_px.blue_in;
        for (int c = 0; c < LANES; c++) begin
            w_oldl[c] = (32'(r_row) >= 32'(w_side)) ? w_l_rdata[16-8*c +: 8] : 8'd0;
            w_ncs[c*CW +: CW] = ((r_row == '0) ? CW'(0) : w_c_rdata[c*CW +: CW])
                                + CW'(w_pxl[c]) - CW'(w_oldl[c]);
        end
    end

    // window sums
    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            n_win[c] = ((r_col == '0) ? WW'(0) : r_win[c]) + WW'(r_ncs[c*CW +: CW])
                       - ((32'(r_col) >= 32'(w_side)) ? WW'(w_c_rdata[c*CW +: CW]) : WW'(0));
        end
    end

    // shared divider
    logic             w_div_start;
    logic [QUOT_W-1:0] w_quot [LANES];
    t_div_status      w_div_st;

    assign w_div_start = (r_state == S_RD2) && w_emit;

    bbum_div #(.NUM_W(WW), .DEN_W(AREAW)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (n_win),
        .i_den    (w_area),
        .o_quot   (w_quot),
        .o_status (w_div_st)
    );

    // sharpen: clamp(2*centre - blur, 0, 255)
    logic [7:0]        w_res [LANES];
    logic signed [9:0] w_s   [LANES];
    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            w_s[c] = $signed({1'b0, r_ctr[16-8*c +: 8], 1'b0}) - $signed({2'b0, w_quot[c]});
            if (!r_sharp) begin
                w_res[c] = w_quot[c];
            end else if (w_s[c][9]) begin
                w_res[c] = 8'd0;
            end else if (w_s[c] > 10'sd255) begin
                w_res[c] = 8'd255;
            end else begin
                w_res[c] = w_s[c][7:0];
            end
        end
    end

    // position advance at the end of each transaction
    logic w_adv;
    logic w_load;
    assign w_load = (r_state == S_FIN) && (!r_oval || !i_stall);
    assign w_adv  = ((r_state == S_RD2) && !w_emit) || w_load;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_ymod = r_ymod;
        if (w_adv) begin
            if ((XW+1)'(r_col) == w_w - 1'b1) begin
                n_col = '0;
                if ((YW+1)'(r_row) == w_h - 1'b1) begin
                    n_row  = '0;
                    n_ymod = '0;
                end else begin
                    n_row  = r_row + 1'b1;
                    n_ymod = (32'(r_ymod) == SL - 1) ? '0 : r_ymod + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        if (i_cfg_we) begin
            n_col  = '0;
            n_row  = '0;
            n_ymod = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = w_emit ? S_DIV : S_IDLE;
            S_DIV:  if (w_div_st.done) n_state = S_FIN;
            S_FIN:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rad   <= RADIUS_RST;
            r_wid   <= WIDTH_RST;
            r_hgt   <= HEIGHT_RST;
            r_sharp <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_ymod  <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_ymod  <= n_ymod;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_RADIUS:  r_rad   <= i_cfg_data[2:0];
                    REG_WIDTH:   r_wid   <= i_cfg_data[11:0];
                    REG_HEIGHT:  r_hgt   <= i_cfg_data[12:0];
                    REG_SHARPEN: r_sharp <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_load) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px <= i_pix;
        end
        if (r_state == S_RD1) begin
            r_ncs <= w_ncs;
        end
        if (r_state == S_RD2) begin
            r_win <= n_win;
            // radius zero: centre is the pixel written this transaction
            r_ctr <= (w_r == '0) ? r_px : w_l_rdata;
        end
        if (w_load) begin
            r_out.red_out   <= w_res[0];
            r_out.green_out <= w_res[1];
            r_out.blue_out  <= w_res[2];
            r_out.col       <= 11'(w_cx);
            r_out.row       <= 12'(w_cy);
            r_out.frame_end <= w_last;
        end
    end

    assign o_valid = r_oval;
    assign o_pix   = r_out;

    `BBUM_ASSERT_NOW(a_div_done_in_div, w_div_st.done, r_state == S_DIV)
    `BBUM_ASSERT_NOW(a_col_in_frame, r_state == S_IDLE, (XW+1)'(r_col) < w_w)
    `BBUM_ASSERT_NEXT(a_start_busy, w_div_start, w_div_st.busy && r_state == S_DIV)

endmodule

[dv/box_blur_and_unsharp_mask_tb.sv]
module box_blur_and_unsharp_mask_tb;
    import bbum_pkg::*;

    localparam int STORE_LINES = 2 * MAX_RADIUS_DEF + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 30;   // covers a pixel still in flight

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 pix_valid = 1'b0;
    logic                 pix_stall;
    t_pix_in              pix_in = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    t_pix_out             res_pix;

    box_blur_and_unsharp_mask u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (pix_valid),
        .o_stall    (pix_stall),
        .i_pix      (pix_in),
        .o_valid    (res_valid),
        .i_stall    (res_stall),
        .o_pix      (res_pix)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Filter predictor: own copy of the registers, line store and sums.
    // ------------------------------------------------------------------
    logic [2:0]  m_radius  = RADIUS_RST;
    logic [11:0] m_width   = WIDTH_RST;
    logic [12:0] m_height  = HEIGHT_RST;
    logic        m_sharpen = 1'b0;

    logic [23:0] lines_mem [STORE_LINES * MAX_WIDTH_DEF];
    int          col_sum   [MAX_WIDTH_DEF][3];
    int          win_sum   [3];
    int          cur_col, cur_row;

    t_pix_out    filtered_q[$];   // expected filtered pixels, oldest first

    bit          idle_en = 1'b1;  // random gaps and stalls allowed
    int          n_sent = 0;
    int          n_errors = 0;
    int          hold_left = 0;   // long receiver hold-off, counted by the receiver
    bit          hold_req = 1'b0;

    task automatic clear_frame();
        foreach (col_sum[i, c]) col_sum[i][c] = 0;
        win_sum = '{0, 0, 0};
        cur_col = 0;
        cur_row = 0;
    endtask

    initial begin
        foreach (lines_mem[i]) lines_mem[i] = '0;
        clear_frame();
    end

    // Work out the result (if any) that one accepted pixel causes.
    task automatic filter_pixel(input t_pix_in p);
        int w, h, r, side, area, x, y, cx, cy, blur, s;
        int px[3], old[3], orig[3];
        logic [23:0] word;
        t_pix_out res;
        w = (m_width == 0) ? 1 : (m_width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : m_width);
        h = (m_height == 0) ? 1 : (m_height > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : m_height);
        r = (m_radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : m_radius;
        side = 2 * r + 1;
        area = side * side;
        if (cur_col >= w || cur_row >= h) clear_frame();
        x = cur_col;
        y = cur_row;
        px = '{p.red_in, p.green_in, p.blue_in};
        old = '{0, 0, 0};
        if (y >= side) begin
            word = lines_mem[((y - side) % STORE_LINES) * MAX_WIDTH_DEF + x];
            old = '{word[23:16], word[15:8], word[7:0]};
        end
        lines_mem[(y % STORE_LINES) * MAX_WIDTH_DEF + x] = p;
        if (x == 0) win_sum = '{0, 0, 0};
        for (int c = 0; c < 3; c++) begin
            col_sum[x][c] += px[c] - old[c];
            win_sum[c] += col_sum[x][c];
            if (x >= side) win_sum[c] -= col_sum[x - side][c];
        end
        if (x >= 2 * r && y >= 2 * r) begin
            cx = x - r;
            cy = y - r;
            word = lines_mem[(cy % STORE_LINES) * MAX_WIDTH_DEF + cx];
            orig = '{word[23:16], word[15:8], word[7:0]};
            for (int c = 0; c < 3; c++) begin
                blur = win_sum[c] / area;
                s = blur;
                if (m_sharpen) begin
                    s = 2 * orig[c] - blur;
                    if (s < 0) s = 0;
                    if (s > 255) s = 255;
                end
                px[c] = s;
            end
            res.red_out   = 8'(px[0]);
            res.green_out = 8'(px[1]);
            res.blue_out  = 8'(px[2]);
            res.col       = 11'(cx);
            res.row       = 12'(cy);
            res.frame_end = (x == w - 1 && y == h - 1);
            filtered_q.push_back(res);
        end
        cur_col = x + 1;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row = y + 1;
            if (cur_row >= h) clear_frame();
        end
    endtask

    // ------------------------------------------------------------------
    // Driving side
    // ------------------------------------------------------------------
    task automatic wait_idle();
        while (filtered_q.size() != 0) @(posedge clk);
        // border pixels give no result but may still be in flight
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write; only issued with the block idle.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RADIUS:  m_radius  = data[2:0];
            REG_WIDTH:   m_width   = data[11:0];
            REG_HEIGHT:  m_height  = data[12:0];
            REG_SHARPEN: m_sharpen = data[0];
            default: ;
        endcase
        clear_frame();
    endtask

    task automatic set_config(input int r, input int w, input int h, input bit sh);
        write_reg(REG_RADIUS, CFG_W'(r));
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
        write_reg(REG_SHARPEN, CFG_W'(sh));
    endtask

    // One pixel transaction. Valid stays high on return so back-to-back
    // transactions need no extra assignment; stop_pixels() drops it.
    task automatic send_pixel(input t_pix_in p);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_in    <= p;
        do @(posedge clk); while (pix_stall);
        filter_pixel(p);
        n_sent++;
    endtask

    task automatic stop_pixels();
        pix_valid <= 1'b0;
    endtask

    function automatic t_pix_in rand_pixel();
        return t_pix_in'(24'($urandom_range(0, 24'hFFFFFF)));
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_pixel(rand_pixel());
        stop_pixels();
    endtask

    // ------------------------------------------------------------------
    // Receiving side: checks every result and drives the result stall.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input t_pix_out exp_pix, input t_pix_out got_pix);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch @%0t exp r%0d g%0d b%0d (%0d,%0d) e%0d got r%0d g%0d b%0d (%0d,%0d) e%0d",
                $time, exp_pix.red_out, exp_pix.green_out, exp_pix.blue_out, exp_pix.col,
                exp_pix.row, exp_pix.frame_end, got_pix.red_out, got_pix.green_out,
                got_pix.blue_out, got_pix.col, got_pix.row, got_pix.frame_end);
    endtask

    int stall_left = 0;

    always @(posedge clk) begin
        t_pix_out exp_pix;
        if (rst_n && res_valid && !res_stall) begin
            if (filtered_q.size() == 0) begin
                report_mismatch('0, res_pix);
            end else begin
                exp_pix = filtered_q.pop_front();
                if (res_pix.red_out !== exp_pix.red_out ||
                    res_pix.green_out !== exp_pix.green_out ||
                    res_pix.blue_out !== exp_pix.blue_out ||
                    res_pix.col !== exp_pix.col || res_pix.row !== exp_pix.row ||
                    res_pix.frame_end !== exp_pix.frame_end)
                    report_mismatch(exp_pix, res_pix);
            end
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            res_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            res_stall <= 1'b1;
        end else begin
            res_stall <= 1'b0;
        end
    end

    // Watchdog
    int cycles = 0;
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: radius 0 blur over 640x480, so every pixel comes back as is.
    task automatic test_reset_defaults();
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hFF00FF);
        send_pixel(24'h00FF00);
        send_pixel(24'h123456);
        stop_pixels();
    endtask

    // 3x3 sharpen over a 4x3 frame with extreme values: clamps both ways,
    // frame end, then wrap into the next frame.
    task automatic test_sharpen_clamp();
        set_config(1, 4, 3, 1'b1);
        for (int i = 0; i < 12; i++)
            send_pixel((i == 5) ? 24'hFF00FF : ((i == 6) ? 24'h00FF00 :
                       ((i % 2) ? 24'h000000 : 24'hFFFFFF)));
        send_random(4);
    endtask

    // Out-of-range sizes: zero saturates to one, oversize to the maximum.
    task automatic test_size_saturation();
        set_config(0, 0, 0, 1'b0);      // 1x1 frame: every pixel is a frame end
        send_random(3);
        set_config(0, 12'hFFF, 13'h1FFF, 1'b1);
        send_random(3);
    endtask

    // Frame narrower than the window: no result at all.
    task automatic test_narrow_frame();
        set_config(2, 3, 6, 1'b0);
        send_random(18);
    endtask

    // Largest window, one full 16x15 frame.
    task automatic test_max_radius();
        set_config(7, 16, 15, 1'b0);
        send_random(240);
    endtask

    // Random settings and frames; mostly whole frames of small size.
    task automatic test_random_frames(input int budget);
        int r, w, h, n;
        bit held;
        held = 1'b0;
        while (budget > 0) begin
            r = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2);
            w = $urandom_range(2 * r + 1, 2 * r + 9);
            h = $urandom_range(2 * r + 1, 2 * r + 6);
            if ($urandom_range(0, 9) == 0) w = $urandom_range(1, 2 * r + 1);
            set_config(r, w, h, $urandom_range(0, 1));
            idle_en = $urandom_range(0, 3) != 0;
            n = w * h * $urandom_range(1, 2) + $urandom_range(0, 3);
            if (!held && budget < 500) begin
                // long receiver hold-off while pixels keep coming
                @(negedge clk) hold_req = 1'b1;
                held = 1'b1;
                n = n + 60;
            end
            send_random(n);
            budget -= n;
        end
        idle_en = 1'b1;
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_full_rate();
        // sender pauses until every expected result has come
        wait_idle();
        idle_en = 1'b0;
        set_config(1, 6, 5, 1'b1);
        send_random(60);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_sharpen_clamp();
        test_size_saturation();
        test_narrow_frame();
        test_max_radius();
        test_random_frames(400);
        test_full_rate();
        while (filtered_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
